// ===== sv/sbpl_pkg.sv =====
// Shared types, codes and limits for the servo bus packet link.
`default_nettype none
package sbpl_pkg;

	// Limits of the packet format
	localparam logic [4:0] MAX_TX_PARAMS  = 5'd16;
	localparam logic [7:0] MAX_STATUS_LEN = 8'd32;
	localparam logic [7:0] MIN_STATUS_LEN = 8'd2;
	localparam logic [7:0] HDR_BYTE       = 8'hff;
	localparam logic [7:0] LEN_INDEX      = 8'd4 - 8'd1;
	localparam logic [7:0] TIMEOUT_DEFAULT = 8'd100;
	localparam int         RES_MAX        = 6;

	typedef enum logic [1:0] {
		IN_START = 2'd0,
		IN_PARAM = 2'd1,
		IN_RX    = 2'd2,
		IN_TICK  = 2'd3
	} in_kind_t;

	typedef enum logic [1:0] {
		OUT_TX     = 2'd0,
		OUT_RX     = 2'd1,
		OUT_FINISH = 2'd2,
		OUT_UNUSED = 2'd3
	} out_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_LENGTH   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_PARAMS = 2'd1,
		PH_RECV   = 2'd2,
		PH_SPARE  = 2'd3
	} phase_t;

	// One input transaction
	typedef struct packed {
		in_kind_t    kind;
		logic [7:0]  servo_id;
		logic [7:0]  instruction;
		logic [4:0]  param_count;
		logic [7:0]  data_byte;
	} item_t;

	// One result transaction (last is derived by the output buffer)
	typedef struct packed {
		out_kind_t   kind;
		logic [7:0]  value;
		logic [7:0]  index;
		status_t     status;
		logic        drive;
	} result_t;

	// Results produced by one item
	typedef struct packed {
		logic [2:0]                 count;
		result_t [RES_MAX-1:0]      res;
	} batch_t;

endpackage
`default_nettype wire

// ===== sv/servo_bus_packet_link_core.sv =====
// An accepted transaction is registered, processed once the result buffer is free, and its
// results are registered in that buffer and offered one a cycle while m_tready is high.
// Throughput: one input transaction per cycle while each yields at most one result and
// m_tready is high; an item with n results (up to six for a start packet) holds the buffer
// until all are taken. Reset: arst_n asynchronously clears the input stage, buffer and
// protocol state (phase idle, counters and sums zero) and loads the timeout with 100 ticks.
`default_nettype none
module servo_bus_packet_link_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// servo_id[7:0], instruction[15:8], param_count[20:16], data_byte[28:21], zero pad
	input  wire logic [31:0] s_tdata,
	// kind[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// byte_value[7:0], byte_index[15:8], finish_status[17:16], zero pad
	output logic [23:0]      m_tdata,
	// out_kind[1:0], drive_line[2]
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);

	logic              valid_s1;
	sbpl_pkg::item_t   item_s1;
	logic              free;
	logic              take;
	sbpl_pkg::batch_t  batch;
	sbpl_pkg::result_t res;
	logic              res_last;

	assign take     = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	// Input stage: hold one transaction until the buffer can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind        <= sbpl_pkg::in_kind_t'(s_tuser);
			item_s1.servo_id    <= s_tdata[7:0];
			item_s1.instruction <= s_tdata[15:8];
			item_s1.param_count <= s_tdata[20:16];
			item_s1.data_byte   <= s_tdata[28:21];
		end
	end

	sbpl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item      (item_s1),
		.batch     (batch)
	);

	sbpl_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.batch    (batch),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res),
		.res_last (res_last)
	);

	// Pack the result transaction
	assign m_tdata = {6'd0, res.status, res.index, res.value};
	assign m_tuser = {res.drive, res.kind};
	assign m_tlast = res_last;

endmodule
`default_nettype wire

// ===== sv/sbpl_engine.sv =====
// Protocol state and per-item result generation for the servo bus packet link.
`default_nettype none
module sbpl_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata,
	input  wire logic            take,
	input  wire sbpl_pkg::item_t item,
	output sbpl_pkg::batch_t     batch
);

	sbpl_pkg::phase_t phase_q, phase_d;
	logic [4:0] params_left_q, params_left_d;
	logic [7:0] tx_sum_q, tx_sum_d;
	logic [7:0] tx_index_q, tx_index_d;
	logic [7:0] rx_count_q, rx_count_d;
	logic [7:0] rx_length_q, rx_length_d;
	logic [7:0] rx_sum_q, rx_sum_d;
	logic [7:0] wait_ticks_q, wait_ticks_d;
	logic [7:0] timeout_q;

	logic [7:0] len;
	logic [7:0] hdr_sum;
	logic [7:0] psum;
	logic [7:0] pidx;
	logic [4:0] pleft;
	logic [7:0] rx_next;
	logic [7:0] wt_next;

	// Build a result record
	function automatic sbpl_pkg::result_t mk(sbpl_pkg::out_kind_t k, logic [7:0] v,
			logic [7:0] i, sbpl_pkg::status_t s, logic d);
		sbpl_pkg::result_t r;
		r.kind   = k;
		r.value  = v;
		r.index  = i;
		r.status = s;
		r.drive  = d;
		return r;
	endfunction

	// Next state and results for the item at hand
	always_comb begin
		phase_d       = phase_q;
		params_left_d = params_left_q;
		tx_sum_d      = tx_sum_q;
		tx_index_d    = tx_index_q;
		rx_count_d    = rx_count_q;
		rx_length_d   = rx_length_q;
		rx_sum_d      = rx_sum_q;
		wait_ticks_d  = wait_ticks_q;
		batch         = '0;
		len           = 8'({3'd0, item.param_count} + 8'd2);
		hdr_sum       = item.servo_id + len + item.instruction;
		psum          = tx_sum_q + item.data_byte;
		pidx          = tx_index_q + 8'd1;
		pleft         = params_left_q - 5'd1;
		rx_next       = rx_count_q + 8'd1;
		wt_next       = (wait_ticks_q == 8'hff) ? wait_ticks_q : wait_ticks_q + 8'd1;
		case (item.kind)
			sbpl_pkg::IN_START: begin
				if (item.param_count > sbpl_pkg::MAX_TX_PARAMS) begin
					phase_d       = sbpl_pkg::PH_IDLE;
					params_left_d = '0;
					batch.count   = 3'd1;
					batch.res[0]  = mk(sbpl_pkg::OUT_FINISH, 8'd0, 8'd0,
						sbpl_pkg::ST_LENGTH, 1'b0);
				end else begin
					batch.res[0]  = mk(sbpl_pkg::OUT_TX, sbpl_pkg::HDR_BYTE, 8'd0,
						sbpl_pkg::ST_OK, 1'b1);
					batch.res[1]  = mk(sbpl_pkg::OUT_TX, sbpl_pkg::HDR_BYTE, 8'd1,
						sbpl_pkg::ST_OK, 1'b1);
					batch.res[2]  = mk(sbpl_pkg::OUT_TX, item.servo_id, 8'd2,
						sbpl_pkg::ST_OK, 1'b1);
					batch.res[3]  = mk(sbpl_pkg::OUT_TX, len, 8'd3,
						sbpl_pkg::ST_OK, 1'b1);
					batch.res[4]  = mk(sbpl_pkg::OUT_TX, item.instruction, 8'd4,
						sbpl_pkg::ST_OK, 1'b1);
					tx_sum_d      = hdr_sum;
					tx_index_d    = 8'd5;
					params_left_d = item.param_count;
					if (item.param_count == 5'd0) begin
						batch.res[5] = mk(sbpl_pkg::OUT_TX, ~hdr_sum, 8'd5,
							sbpl_pkg::ST_OK, 1'b1);
						batch.count  = 3'd6;
						phase_d      = sbpl_pkg::PH_RECV;
						rx_count_d   = '0;
						rx_length_d  = '0;
						rx_sum_d     = '0;
						wait_ticks_d = '0;
					end else begin
						batch.count  = 3'd5;
						phase_d      = sbpl_pkg::PH_PARAMS;
					end
				end
			end
			sbpl_pkg::IN_PARAM: begin
				if (phase_q == sbpl_pkg::PH_PARAMS) begin
					batch.res[0]  = mk(sbpl_pkg::OUT_TX, item.data_byte, tx_index_q,
						sbpl_pkg::ST_OK, 1'b1);
					tx_sum_d      = psum;
					tx_index_d    = pidx;
					params_left_d = pleft;
					if (pleft == 5'd0) begin
						batch.res[1] = mk(sbpl_pkg::OUT_TX, ~psum, pidx,
							sbpl_pkg::ST_OK, 1'b1);
						batch.count  = 3'd2;
						phase_d      = sbpl_pkg::PH_RECV;
						rx_count_d   = '0;
						rx_length_d  = '0;
						rx_sum_d     = '0;
						wait_ticks_d = '0;
					end else begin
						batch.count  = 3'd1;
					end
				end
			end
			sbpl_pkg::IN_RX: begin
				if (phase_q == sbpl_pkg::PH_RECV) begin
					wait_ticks_d = '0;
					rx_count_d   = rx_next;
					batch.count  = 3'd1;
					batch.res[0] = mk(sbpl_pkg::OUT_RX, item.data_byte, rx_count_q,
						sbpl_pkg::ST_OK, 1'b0);
					if (rx_count_q == sbpl_pkg::LEN_INDEX) begin
						// Status length byte
						rx_length_d = item.data_byte;
						rx_sum_d    = rx_sum_q + item.data_byte;
						if (item.data_byte > sbpl_pkg::MAX_STATUS_LEN ||
								item.data_byte < sbpl_pkg::MIN_STATUS_LEN) begin
							phase_d      = sbpl_pkg::PH_IDLE;
							batch.count  = 3'd2;
							batch.res[1] = mk(sbpl_pkg::OUT_FINISH, 8'd0, rx_next,
								sbpl_pkg::ST_LENGTH, 1'b0);
						end
					end else if (rx_count_q < sbpl_pkg::LEN_INDEX) begin
						// Header bytes pass unchecked; the id joins the sum
						if (rx_count_q == 8'd2) begin
							rx_sum_d = rx_sum_q + item.data_byte;
						end
					end else if (rx_count_q == sbpl_pkg::LEN_INDEX + rx_length_q) begin
						// Checksum byte closes the status packet
						phase_d      = sbpl_pkg::PH_IDLE;
						batch.count  = 3'd2;
						batch.res[1] = mk(sbpl_pkg::OUT_FINISH, 8'd0, rx_next,
							(~rx_sum_q == item.data_byte) ? sbpl_pkg::ST_OK
								: sbpl_pkg::ST_CHECKSUM, 1'b0);
					end else begin
						rx_sum_d = rx_sum_q + item.data_byte;
					end
				end
			end
			sbpl_pkg::IN_TICK: begin
				if (phase_q == sbpl_pkg::PH_RECV) begin
					wait_ticks_d = wt_next;
					if (wt_next >= timeout_q) begin
						phase_d      = sbpl_pkg::PH_IDLE;
						batch.count  = 3'd1;
						batch.res[0] = mk(sbpl_pkg::OUT_FINISH, 8'd0, rx_count_q,
							sbpl_pkg::ST_TIMEOUT, 1'b0);
					end
				end
			end
			default: begin
				batch = '0;
			end
		endcase
	end

	// Hold protocol state; advance on each item taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= sbpl_pkg::PH_IDLE;
			params_left_q <= '0;
			tx_sum_q      <= '0;
			tx_index_q    <= '0;
			rx_count_q    <= '0;
			rx_length_q   <= '0;
			rx_sum_q      <= '0;
			wait_ticks_q  <= '0;
		end else if (take) begin
			phase_q       <= phase_d;
			params_left_q <= params_left_d;
			tx_sum_q      <= tx_sum_d;
			tx_index_q    <= tx_index_d;
			rx_count_q    <= rx_count_d;
			rx_length_q   <= rx_length_d;
			rx_sum_q      <= rx_sum_d;
			wait_ticks_q  <= wait_ticks_d;
		end
	end

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbpl_pkg::TIMEOUT_DEFAULT;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbpl_out_buf.sv =====
// Result buffer: holds the results of one item and hands them out in order.
`default_nettype none
module sbpl_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire sbpl_pkg::batch_t batch,
	output logic                  free,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output sbpl_pkg::result_t     res,
	output logic                  res_last
);

	sbpl_pkg::result_t [sbpl_pkg::RES_MAX-1:0] res_q;
	logic [2:0] cnt_q;
	logic [2:0] ptr_q;
	logic       take;

	assign m_tvalid = (cnt_q != 3'd0);
	assign res      = res_q[ptr_q];
	assign res_last = (ptr_q == cnt_q - 3'd1);
	assign take     = m_tvalid && m_tready;
	assign free     = !m_tvalid || (take && res_last);

	// Load a new batch or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
			ptr_q <= '0;
		end else if (take) begin
			if (res_last) begin
				cnt_q <= '0;
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 3'd1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbpl_checker.sv =====
// Port-level checks for the servo bus packet link, bound to the top level.
`default_nettype none
module sbpl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	// A stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// The line is driven exactly for transmit bytes
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == sbpl_pkg::OUT_TX)))
		else $error("drive_line disagrees with result kind");

	// A finish result closes the results of its item
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == sbpl_pkg::OUT_FINISH |-> m_tlast)
		else $error("finish result not last");

	// Byte results carry a clear status and no unused kind appears
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != sbpl_pkg::OUT_FINISH
			|-> m_tdata[17:16] == sbpl_pkg::ST_OK && m_tuser[1:0] != sbpl_pkg::OUT_UNUSED)
		else $error("byte result with status or bad kind");

endmodule

bind servo_bus_packet_link_core sbpl_checker u_sbpl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/sv/servo_bus_packet_link_core_tb.sv =====
// Self-checking testbench for the servo bus packet link core.
`timescale 1ns / 1ps
module servo_bus_packet_link_core_tb;
	import sbpl_pkg::*;

	// How a stimulus row gets its expected results
	localparam int ROW_PREDICT = 0;
	localparam int ROW_NONE    = 1;
	localparam int ROW_FINISH  = 2;

	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASE_ITEMS   = 26;

	// One expected output transaction
	typedef struct packed {
		out_kind_t  kind;
		logic [7:0] value;
		logic [7:0] index;
		status_t    status;
		logic       drive;
		logic       last;
	} link_out_t;

	// One row of the directed table
	typedef struct {
		item_t      it;
		int         code;
		status_t    st;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// Shadow of the block's protocol state and timeout register
	phase_t      link_phase;
	logic [4:0]  params_remaining;
	logic [7:0]  tx_csum;
	logic [7:0]  tx_pos;
	logic [15:0] rx_pos;
	logic [7:0]  status_len;
	logic [7:0]  rx_csum;
	logic [7:0]  idle_ticks;
	logic [7:0]  timeout_limit;

	link_out_t   step_out[$];
	logic        step_used;
	link_out_t   link_out_due[$];
	dir_row_t    dir_rows[$];

	int          errors = 0;
	int          items_done = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	bit          hold_request = 1'b0;

	servo_bus_packet_link_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop if the block hangs
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		begin
			roll = $urandom_range(0, 99);
			if (roll < 65)
				return 0;
			else if (roll < 95)
				return $urandom_range(1, 3);
			else
				return $urandom_range(10, 40);
		end
	endfunction

	function automatic item_t rand_item(input in_kind_t k);
		item_t it;
		begin
			it.kind        = k;
			it.servo_id    = 8'($urandom);
			it.instruction = 8'($urandom);
			it.param_count = 5'($urandom_range(0, 31));
			it.data_byte   = 8'($urandom);
			return it;
		end
	endfunction

	task automatic emit(input out_kind_t k, input logic [7:0] v, input logic [7:0] ix,
			input status_t st, input logic drv);
		link_out_t r;
		begin
			r.kind   = k;
			r.value  = v;
			r.index  = ix;
			r.status = st;
			r.drive  = drv;
			r.last   = 1'b0;
			step_out.push_back(r);
		end
	endtask

	// Send the checksum byte and turn the line round to receive
	task automatic close_tx();
		begin
			emit(OUT_TX, ~tx_csum, tx_pos, ST_OK, 1'b1);
			link_phase = PH_RECV;
			rx_pos     = 16'd0;
			status_len = 8'd0;
			rx_csum    = 8'd0;
			idle_ticks = 8'd0;
		end
	endtask

	// Advance the shadow state by one input transaction and collect its results
	task automatic link_step(input item_t it);
		logic [7:0]  hdr_len;
		logic [15:0] pos;
		logic [7:0]  want_csum;
		begin
			step_out.delete();
			step_used = 1'b0;
			case (it.kind)
				IN_START: begin
					step_used = 1'b1;
					if (it.param_count > MAX_TX_PARAMS) begin
						link_phase       = PH_IDLE;
						params_remaining = 5'd0;
						emit(OUT_FINISH, 8'd0, 8'd0, ST_LENGTH, 1'b0);
					end else begin
						hdr_len = {3'b000, it.param_count} + 8'd2;
						emit(OUT_TX, HDR_BYTE, 8'd0, ST_OK, 1'b1);
						emit(OUT_TX, HDR_BYTE, 8'd1, ST_OK, 1'b1);
						emit(OUT_TX, it.servo_id, 8'd2, ST_OK, 1'b1);
						emit(OUT_TX, hdr_len, 8'd3, ST_OK, 1'b1);
						emit(OUT_TX, it.instruction, 8'd4, ST_OK, 1'b1);
						tx_csum          = it.servo_id + hdr_len + it.instruction;
						tx_pos           = 8'd5;
						params_remaining = it.param_count;
						if (it.param_count == 5'd0)
							close_tx();
						else
							link_phase = PH_PARAMS;
					end
				end
				IN_PARAM: begin
					if (link_phase == PH_PARAMS) begin
						step_used = 1'b1;
						emit(OUT_TX, it.data_byte, tx_pos, ST_OK, 1'b1);
						tx_csum          = tx_csum + it.data_byte;
						tx_pos           = tx_pos + 8'd1;
						params_remaining = params_remaining - 5'd1;
						if (params_remaining == 5'd0)
							close_tx();
					end
				end
				IN_RX: begin
					if (link_phase == PH_RECV) begin
						step_used  = 1'b1;
						pos        = rx_pos;
						idle_ticks = 8'd0;
						emit(OUT_RX, it.data_byte, pos[7:0], ST_OK, 1'b0);
						rx_pos = pos + 16'd1;
						if (pos == 16'd3) begin
							status_len = it.data_byte;
							rx_csum    = rx_csum + it.data_byte;
							if (it.data_byte > MAX_STATUS_LEN ||
									it.data_byte < MIN_STATUS_LEN) begin
								link_phase = PH_IDLE;
								emit(OUT_FINISH, 8'd0, rx_pos[7:0], ST_LENGTH, 1'b0);
							end
						end else if (pos < 16'd3) begin
							if (pos == 16'd2)
								rx_csum = rx_csum + it.data_byte;
						end else if (pos == 16'd3 + {8'd0, status_len}) begin
							want_csum  = ~rx_csum;
							link_phase = PH_IDLE;
							emit(OUT_FINISH, 8'd0, rx_pos[7:0],
								(want_csum == it.data_byte) ? ST_OK : ST_CHECKSUM, 1'b0);
						end else begin
							rx_csum = rx_csum + it.data_byte;
						end
					end
				end
				default: begin
					if (link_phase == PH_RECV) begin
						step_used = 1'b1;
						if (idle_ticks != 8'hff)
							idle_ticks = idle_ticks + 8'd1;
						if (idle_ticks >= timeout_limit) begin
							link_phase = PH_IDLE;
							emit(OUT_FINISH, 8'd0, rx_pos[7:0], ST_TIMEOUT, 1'b0);
						end
					end
				end
			endcase
			if (step_out.size() > 0)
				step_out[step_out.size() - 1].last = 1'b1;
		end
	endtask

	// Offer one item after a random gap, wait for the transaction, then book its results
	task automatic send_item(input item_t it, input int code, input status_t st,
			input logic [7:0] idx);
		int gap;
		link_out_t r;
		begin
			gap = src_idle_on ? pick_gap() : 0;
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			@(negedge clk);
			s_tvalid <= 1'b1;
			s_tdata  <= {3'b000, it.data_byte, it.param_count, it.instruction, it.servo_id};
			s_tuser  <= it.kind;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			link_step(it);
			if (code == ROW_PREDICT) begin
				foreach (step_out[i])
					link_out_due.push_back(step_out[i]);
			end else if (code == ROW_FINISH) begin
				r.kind   = OUT_FINISH;
				r.value  = 8'd0;
				r.index  = idx;
				r.status = st;
				r.drive  = 1'b0;
				r.last   = 1'b1;
				link_out_due.push_back(r);
			end
			if (step_used)
				items_done++;
		end
	endtask

	task automatic add_row(input in_kind_t k, input logic [7:0] id, input logic [7:0] ins,
			input logic [4:0] cnt, input logic [7:0] d, input int code, input status_t st);
		dir_row_t row;
		begin
			row.it.kind        = k;
			row.it.servo_id    = id;
			row.it.instruction = ins;
			row.it.param_count = cnt;
			row.it.data_byte   = d;
			row.code           = code;
			row.st             = st;
			dir_rows.push_back(row);
		end
	endtask

	// Drop valid and let every booked result drain before touching the register
	task automatic settle_link();
		begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (link_out_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_timeout(input logic [7:0] v);
		begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= v;
			@(negedge clk);
			cfg_we    <= 1'b0;
			timeout_limit = v;
		end
	endtask

	// One command packet and its status reply, with noise and broken replies mixed in
	task automatic run_transfer();
		int         roll;
		int         cnt;
		int         len;
		int         stop_at;
		int         i;
		int         n;
		logic [7:0] sum;
		logic [7:0] csum;
		logic [7:0] reply[$];
		item_t      it;
		begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				cnt = $urandom_range(17, 31);
			else if (roll < 12)
				cnt = 16;
			else if (roll < 24)
				cnt = $urandom_range(5, 15);
			else
				cnt = $urandom_range(0, 4);
			it = rand_item(IN_START);
			it.param_count = 5'(cnt);
			send_item(it, ROW_PREDICT, ST_OK, 8'd0);
			if (cnt > 16)
				return;

			// Parameter bytes, with stray line bytes and ticks in between
			for (i = 0; i < cnt; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					return;
				if (roll < 12)
					send_item(rand_item(($urandom_range(0, 1) != 0) ? IN_RX : IN_TICK),
						ROW_PREDICT, ST_OK, 8'd0);
				send_item(rand_item(IN_PARAM), ROW_PREDICT, ST_OK, 8'd0);
			end

			// Build the status reply
			roll = $urandom_range(0, 99);
			if (roll < 4)
				len = $urandom_range(0, 1);
			else if (roll < 8)
				len = $urandom_range(33, 255);
			else if (roll < 18)
				len = 32;
			else if (roll < 30)
				len = $urandom_range(7, 31);
			else
				len = $urandom_range(2, 6);
			if ($urandom_range(0, 9) == 0) begin
				reply.push_back(8'($urandom));
				reply.push_back(8'($urandom));
			end else begin
				reply.push_back(HDR_BYTE);
				reply.push_back(HDR_BYTE);
			end
			reply.push_back(8'($urandom));
			reply.push_back(len[7:0]);
			sum = reply[2] + reply[3];
			if (len >= 2 && len <= 32) begin
				for (i = 0; i < len - 1; i++) begin
					reply.push_back(8'($urandom));
					sum = sum + reply[reply.size() - 1];
				end
				csum = ~sum;
				if ($urandom_range(0, 99) < 15)
					csum = csum ^ 8'($urandom_range(1, 255));
				reply.push_back(csum);
			end

			// Cut the reply short now and then: time it out or abandon it
			stop_at = reply.size();
			if ($urandom_range(0, 99) < 15)
				stop_at = $urandom_range(0, reply.size() - 1);
			i = 0;
			while (link_phase == PH_RECV && i < stop_at) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					n = $urandom_range(1, 2);
					repeat (n) send_item(rand_item(IN_TICK), ROW_PREDICT, ST_OK, 8'd0);
				end else if (roll < 11) begin
					send_item(rand_item(IN_PARAM), ROW_PREDICT, ST_OK, 8'd0);
				end
				if (link_phase == PH_RECV) begin
					it = rand_item(IN_RX);
					it.data_byte = reply[i];
					send_item(it, ROW_PREDICT, ST_OK, 8'd0);
				end
				i++;
			end
			if (stop_at < reply.size() && timeout_limit <= 8'd40 &&
					$urandom_range(0, 1) != 0) begin
				while (link_phase == PH_RECV)
					send_item(rand_item(IN_TICK), ROW_PREDICT, ST_OK, 8'd0);
			end
		end
	endtask

	// Compare one field of an output transaction
	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		begin
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
				errors++;
			end
		end
	endtask

	// Check each output transaction against the oldest booked result
	always @(posedge clk) begin : watch_out
		link_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (link_out_due.size() == 0) begin
				$display("%0t: unexpected output, expected none, got data %0h user %0h last %0b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = link_out_due.pop_front();
				check_field("out_kind", {6'd0, want.kind}, {6'd0, m_tuser[1:0]});
				check_field("byte_value", want.value, m_tdata[7:0]);
				check_field("byte_index", want.index, m_tdata[15:8]);
				check_field("finish_status", {6'd0, want.status}, {6'd0, m_tdata[17:16]});
				check_field("drive_line", {7'd0, want.drive}, {7'd0, m_tuser[2]});
				check_field("last", {7'd0, want.last}, {7'd0, m_tlast});
			end
		end
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin : sink
		int gap;
		int hold_count;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(negedge clk);
					hold_count++;
				end
				m_tready <= 1'b1;
				hold_request = 1'b0;
			end else begin
				gap = sink_idle_on ? pick_gap() : 0;
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Main sequence
	initial begin : stimulus
		logic [7:0] cfg_plan[6];
		int         waited;
		int         target;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 8'd0;
		s_tvalid  = 1'b0;
		s_tdata   = 32'd0;
		s_tuser   = 2'd0;

		link_phase       = PH_IDLE;
		params_remaining = 5'd0;
		tx_csum          = 8'd0;
		tx_pos           = 8'd0;
		rx_pos           = 16'd0;
		status_len       = 8'd0;
		rx_csum          = 8'd0;
		idle_ticks       = 8'd0;
		timeout_limit    = TIMEOUT_DEFAULT;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Stray items while idle, oversize parameter counts
		add_row(IN_TICK,  8'h00, 8'h00, 5'd0,  8'h00, ROW_NONE,   ST_OK);
		add_row(IN_PARAM, 8'h00, 8'h00, 5'd0,  8'hff, ROW_NONE,   ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hff, ROW_NONE,   ST_OK);
		add_row(IN_START, 8'hff, 8'hff, 5'd17, 8'h00, ROW_FINISH, ST_LENGTH);
		add_row(IN_START, 8'h00, 8'h00, 5'd31, 8'hff, ROW_FINISH, ST_LENGTH);
		// One parameter, then a status length above the limit
		add_row(IN_START, 8'hff, 8'hff, 5'd1,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_PARAM, 8'h00, 8'h00, 5'd0,  8'hff, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hff, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hff, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h01, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h21, ROW_PREDICT, ST_OK);
		// No parameters, then a status length below the limit
		add_row(IN_START, 8'h00, 8'h00, 5'd0,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hff, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hff, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hfe, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h01, ROW_PREDICT, ST_OK);
		// Start while busy, then a clean reply
		add_row(IN_START, 8'h01, 8'h02, 5'd2,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_PARAM, 8'h00, 8'h00, 5'd0,  8'h55, ROW_PREDICT, ST_OK);
		add_row(IN_START, 8'h01, 8'h00, 5'd0,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h01, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h02, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'h00, ROW_PREDICT, ST_OK);
		add_row(IN_RX,    8'h00, 8'h00, 5'd0,  8'hfc, ROW_PREDICT, ST_OK);

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].code, dir_rows[i].st, 8'd0);

		// Random phases, each under its own timeout setting
		cfg_plan = '{8'd0, 8'd255, 8'd5, 8'd1, 8'($urandom_range(2, 60)), 8'd20};
		target = items_done;
		foreach (cfg_plan[p]) begin
			settle_link();
			write_timeout(cfg_plan[p]);
			src_idle_on  = (p != 2);
			sink_idle_on = (p != 2);
			if (p == 3)
				hold_request = 1'b1;
			target = target + PHASE_ITEMS;
			while (items_done < target)
				run_transfer();
		end

		// Drain what is still booked
		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (link_out_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (link_out_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, link_out_due.size());
			errors++;
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
